[rtl/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs i_clk and i_rst_n visible at the place of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/fra_pkg.sv]
// Shared constants, types and helpers for the fraction ALU.
// No dependencies.
package fra_pkg;

    localparam int OPERAND_WIDTH = 16;
    localparam int MAG_W         = 2 * OPERAND_WIDTH + 1;
    localparam int PROD_W        = 2 * OPERAND_WIDTH;
    localparam int RES_W         = 33;
    localparam int ERR_W         = 2;
    localparam int OP_W          = 2;
    localparam int IN_DATA_W     = ((4 * OPERAND_WIDTH + 7) / 8) * 8;
    localparam int OUT_DATA_W    = ((2 * RES_W + 7) / 8) * 8;
    localparam int SHIFT_W       = $clog2(MAG_W + 1);
    localparam int CNT_W         = $clog2(MAG_W);
    localparam int EXT_W         = (MAG_W > RES_W) ? MAG_W : RES_W;
    localparam int QDEPTH        = 2;
    localparam int QPTR_W        = $clog2(QDEPTH);

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [ERR_W-1:0] {
        ERR_OK       = 2'd0,
        ERR_ZERO_DEN = 2'd1,
        ERR_DIV_ZERO = 2'd2
    } t_err;

    typedef struct packed {
        logic                     neg;
        logic [OPERAND_WIDTH-1:0] mag;
    } t_smag;

    typedef struct packed {
        t_err             err;
        logic             n_neg;
        logic [MAG_W-1:0] n_mag;
        logic             d_neg;
        logic [MAG_W-1:0] d_mag;
    } t_job;

    function automatic t_smag to_smag(input logic [OPERAND_WIDTH-1:0] v);
        t_smag r;
        r.neg = v[OPERAND_WIDTH-1];
        r.mag = r.neg ? (~v + 1'b1) : v;
        return r;
    endfunction

    // sign-magnitude to two's complement, wrapped to the result width
    function automatic logic [RES_W-1:0] to_out(input logic neg, input logic [MAG_W-1:0] mag);
        logic [EXT_W-1:0] e;
        e = EXT_W'(mag);
        if (neg) begin
            e = ~e + 1'b1;
        end
        return e[RES_W-1:0];
    endfunction

endpackage

[rtl/fraction_alu_with_reduction_unit.sv]
// Top level of the fraction ALU: front end, job queue, back end.
// Depends on fra_pkg, fra_front, fra_queue, fra_back.
//
//  channel  dir  tdata                              tuser
//  s_axis   in   ln, ld, rn, rd (16 b each)         operation (2 b)
//  m_axis   out  reduced num, reduced den (33 b)    error_code (2 b)
//
// Front: an accepted request steps through F_MUL_A, F_MUL_B and F_MUL_D to
// F_PUSH (straight to F_PUSH on an error) and waits there while the queue is full.
// Back: binary gcd, then two MAG_W-bit divisions (one bit per cycle).
// Reset (synchronous, active low) empties the queue and clears all valids.
// The 2-entry queue lets the front take a new request while the back is busy;
// a stalled result waits in the output register without blocking the gcd.
module fraction_alu_with_reduction_unit import fra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [15:0] left_numerator, [31:16] left_denominator,
    // [47:32] right_numerator, [63:48] right_denominator
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [1:0] operation
    input  logic [OP_W-1:0]       s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [32:0] reduced_numerator, [65:33] reduced_denominator, rest zero
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    // [1:0] error_code
    output logic [ERR_W-1:0]      m_axis_tuser
);

    logic             push, full, pop, empty;
    t_job             job_in, job_out;
    logic [RES_W-1:0] res_n, res_d;
    t_err             res_err;

    fra_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_op    (t_op'(s_axis_tuser)),
        .i_data  (s_axis_tdata),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    fra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_job   (job_out),
        .o_empty (empty)
    );

    fra_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_job   (job_out),
        .o_pop   (pop),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_num   (res_n),
        .o_den   (res_d),
        .o_err   (res_err)
    );

    assign m_axis_tdata = {(OUT_DATA_W - 2 * RES_W)'(0), res_d, res_n};
    assign m_axis_tuser = res_err;

endmodule

[rtl/fra_front.sv]
// Front end: accepts a request, checks for errors, forms raw numerator and
// denominator with one shared multiplier. Depends on fra_pkg.
module fra_front import fra_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_op                  i_op,
    input  logic [IN_DATA_W-1:0] i_data,
    output logic                 o_push,
    output t_job                 o_job,
    input  logic                 i_full
);

    typedef enum logic [4:0] {
        F_IDLE  = 5'b00001,
        F_MUL_A = 5'b00010,
        F_MUL_B = 5'b00100,
        F_MUL_D = 5'b01000,
        F_PUSH  = 5'b10000
    } t_fstate;

    t_fstate r_state, n_state;
    t_op     r_op;
    t_err    r_err;
    t_smag   r_ln, r_ld, r_rn, r_rd;
    logic    r_pa_neg, r_pb_neg, r_pd_neg;
    logic [PROD_W-1:0] r_pa, r_pb, r_pd;

    t_smag in_ln, in_ld, in_rn, in_rd;
    t_smag mx, my;
    logic [PROD_W-1:0] prod;
    logic              prod_neg;
    logic              a_neg, b_neg;
    logic [MAG_W-1:0]  a_mag, b_mag;
    logic              sum_neg;
    logic [MAG_W-1:0]  sum_mag;
    logic              accept;

    assign in_ln = to_smag(i_data[0*OPERAND_WIDTH +: OPERAND_WIDTH]);
    assign in_ld = to_smag(i_data[1*OPERAND_WIDTH +: OPERAND_WIDTH]);
    assign in_rn = to_smag(i_data[2*OPERAND_WIDTH +: OPERAND_WIDTH]);
    assign in_rd = to_smag(i_data[3*OPERAND_WIDTH +: OPERAND_WIDTH]);

    assign o_ready = (r_state == F_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        mx = r_ln;
        my = r_rd;
        unique case (r_state)
            F_MUL_A: begin
                unique case (r_op)
                    OP_ADD, OP_SUB: begin mx = r_rn; my = r_ld; end
                    OP_MUL:         begin mx = r_rn; my = r_ln; end
                    OP_DIV:         begin mx = r_ln; my = r_rd; end
                    default:        begin mx = r_ln; my = r_rd; end
                endcase
            end
            F_MUL_D: begin
                if (r_op == OP_DIV) begin
                    mx = r_ld; my = r_rn;
                end else begin
                    mx = r_rd; my = r_ld;
                end
            end
            default: begin mx = r_ln; my = r_rd; end
        endcase
    end

    assign prod     = PROD_W'(mx.mag) * PROD_W'(my.mag);
    assign prod_neg = mx.neg ^ my.neg;

    // numerator: term A (negated for subtract) plus term B (add/sub only)
    always_comb begin
        a_mag = MAG_W'(r_pa);
        a_neg = (r_op == OP_SUB) ? ~r_pa_neg : r_pa_neg;
        b_mag = (r_op == OP_ADD || r_op == OP_SUB) ? MAG_W'(r_pb) : '0;
        b_neg = (r_op == OP_ADD || r_op == OP_SUB) ? r_pb_neg : 1'b0;
        if (a_neg == b_neg) begin
            sum_neg = a_neg;
            sum_mag = a_mag + b_mag;
        end else if (a_mag >= b_mag) begin
            sum_neg = a_neg;
            sum_mag = a_mag - b_mag;
        end else begin
            sum_neg = b_neg;
            sum_mag = b_mag - a_mag;
        end
    end

    always_comb begin
        o_push = (r_state == F_PUSH);
        o_job.err = r_err;
        if (r_err == ERR_OK) begin
            o_job.n_neg = sum_neg;
            o_job.n_mag = sum_mag;
            o_job.d_neg = r_pd_neg;
            o_job.d_mag = MAG_W'(r_pd);
        end else begin
            o_job.n_neg = 1'b0;
            o_job.n_mag = '0;
            o_job.d_neg = 1'b0;
            o_job.d_mag = '0;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            F_IDLE: begin
                if (accept) begin
                    if (in_ld.mag == '0 || in_rd.mag == '0 ||
                        (i_op == OP_DIV && in_rn.mag == '0)) begin
                        n_state = F_PUSH;
                    end else begin
                        n_state = F_MUL_A;
                    end
                end
            end
            F_MUL_A: n_state = F_MUL_B;
            F_MUL_B: n_state = F_MUL_D;
            F_MUL_D: n_state = F_PUSH;
            F_PUSH:  if (!i_full) n_state = F_IDLE;
            default: n_state = F_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op <= i_op;
            r_ln <= in_ln;
            r_ld <= in_ld;
            r_rn <= in_rn;
            r_rd <= in_rd;
            priority if (in_ld.mag == '0 || in_rd.mag == '0) begin
                r_err <= ERR_ZERO_DEN;
            end else if (i_op == OP_DIV && in_rn.mag == '0) begin
                r_err <= ERR_DIV_ZERO;
            end else begin
                r_err <= ERR_OK;
            end
        end
        if (r_state == F_MUL_A) begin
            r_pa     <= prod;
            r_pa_neg <= prod_neg;
        end
        if (r_state == F_MUL_B) begin
            r_pb     <= prod;
            r_pb_neg <= prod_neg;
        end
        if (r_state == F_MUL_D) begin
            r_pd     <= prod;
            r_pd_neg <= prod_neg;
        end
    end

endmodule

[rtl/fra_queue.sv]
// Small job queue between front and back end.
// Depends on fra_pkg.
module fra_queue import fra_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    output logic o_full,
    input  logic i_pop,
    output t_job o_job,
    output logic o_empty
);

    localparam logic [QPTR_W:0] FULL_CNT = (QPTR_W + 1)'(QDEPTH);

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_cnt;
    logic              do_push, do_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == QPTR_W'(QDEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == QPTR_W'(QDEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + (QPTR_W + 1)'(do_push) - (QPTR_W + 1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

endmodule

[rtl/fra_back.sv]
// Back end: binary gcd, then two bit-serial divisions by the gcd, then the output
// register; errors and zero numerators go straight to the output. Depends on fra_pkg.
module fra_back import fra_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_job                  i_job,
    output logic                  o_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [RES_W-1:0]      o_num,
    output logic [RES_W-1:0]      o_den,
    output t_err                  o_err
);

    typedef enum logic [4:0] {
        B_IDLE = 5'b00001,
        B_GCD  = 5'b00010,
        B_DIVN = 5'b00100,
        B_DIVD = 5'b01000,
        B_DONE = 5'b10000
    } t_bstate;

    t_bstate r_state, n_state;
    t_job    r_job;
    logic [MAG_W-1:0]   r_a, r_b, r_g, r_q, r_rem, r_qn;
    logic [SHIFT_W-1:0] r_k;
    logic [CNT_W-1:0]   r_cnt;
    logic [RES_W-1:0]   r_res_n, r_res_d;
    t_err               r_res_err;
    logic               r_ovalid;
    logic [RES_W-1:0]   r_out_n, r_out_d;
    t_err               r_out_err;

    logic [MAG_W:0]   rem_sh;
    logic             q_bit;
    logic [MAG_W-1:0] rem_nx, q_nx;
    logic             div_last;
    logic             load_out;
    logic             direct;

    assign o_pop    = (r_state == B_IDLE) && !i_empty;
    assign direct   = (i_job.err != ERR_OK) || (i_job.n_mag == '0);
    assign div_last = (r_cnt == CNT_W'(MAG_W - 1));
    assign load_out = (r_state == B_DONE) && (!r_ovalid || i_ready);

    // one restoring division step
    assign rem_sh = {r_rem, r_q[MAG_W-1]};
    assign q_bit  = (rem_sh >= {1'b0, r_g});
    assign rem_nx = q_bit ? MAG_W'(rem_sh - {1'b0, r_g}) : rem_sh[MAG_W-1:0];
    assign q_nx   = {r_q[MAG_W-2:0], q_bit};

    assign o_valid = r_ovalid;
    assign o_num   = r_out_n;
    assign o_den   = r_out_d;
    assign o_err   = r_out_err;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            B_IDLE:  if (o_pop) n_state = direct ? B_DONE : B_GCD;
            B_GCD:   if (r_a == '0) n_state = B_DIVN;
            B_DIVN:  if (div_last) n_state = B_DIVD;
            B_DIVD:  if (div_last) n_state = B_DONE;
            B_DONE:  if (load_out) n_state = B_IDLE;
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= B_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_out) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            B_IDLE: begin
                if (o_pop) begin
                    r_job <= i_job;
                    r_a   <= i_job.n_mag;
                    r_b   <= i_job.d_mag;
                    r_k   <= '0;
                    r_res_err <= i_job.err;
                    if (i_job.err != ERR_OK) begin
                        r_res_n <= '0;
                        r_res_d <= '0;
                    end else begin
                        // zero numerator: 0 over the sign of the denominator
                        r_res_n <= '0;
                        r_res_d <= to_out(i_job.d_neg, MAG_W'(1));
                    end
                end
            end
            B_GCD: begin
                priority if (r_a == '0) begin
                    r_g   <= r_b << r_k;
                    r_q   <= r_job.n_mag;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else if (!r_a[0] && !r_b[0]) begin
                    r_a <= r_a >> 1;
                    r_b <= r_b >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_a[0]) begin
                    r_a <= r_a >> 1;
                end else if (!r_b[0]) begin
                    r_b <= r_b >> 1;
                end else if (r_a >= r_b) begin
                    r_a <= (r_a - r_b) >> 1;
                end else begin
                    r_b <= (r_b - r_a) >> 1;
                end
            end
            B_DIVN: begin
                r_cnt <= r_cnt + 1'b1;
                if (div_last) begin
                    r_qn  <= q_nx;
                    r_q   <= r_job.d_mag;
                    r_rem <= '0;
                    r_cnt <= '0;
                end else begin
                    r_q   <= q_nx;
                    r_rem <= rem_nx;
                end
            end
            B_DIVD: begin
                r_cnt <= r_cnt + 1'b1;
                r_q   <= q_nx;
                r_rem <= rem_nx;
                if (div_last) begin
                    r_res_n <= to_out(r_job.n_neg, r_qn);
                    r_res_d <= to_out(r_job.d_neg, q_nx);
                end
            end
            B_DONE: begin
                if (load_out) begin
                    r_out_n   <= r_res_n;
                    r_out_d   <= r_res_d;
                    r_out_err <= r_res_err;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

[rtl/fra_checker.sv]
// Port-level checker for the fraction ALU, bound to the top level.
// Depends on fra_pkg and assert_macros.svh.
`include "assert_macros.svh"

module fra_checker import fra_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic [IN_DATA_W-1:0]  s_axis_tdata,
    input logic [OP_W-1:0]       s_axis_tuser,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [ERR_W-1:0]      m_axis_tuser
);

    `ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result dropped while stalled")
    `ASSERT_NEXT(a_front_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "front took two requests back to back")
    `ASSERT_IMPL(a_err_zero, m_axis_tvalid && m_axis_tuser != ERR_OK, m_axis_tdata == '0, "error result carries data")
    `ASSERT_IMPL(a_den_nonzero, m_axis_tvalid && m_axis_tuser == ERR_OK, m_axis_tdata[2*RES_W-1:RES_W] != '0, "zero denominator on good result")

endmodule

bind fraction_alu_with_reduction_unit fra_checker u_chk (.*);
